/* rtl/ptz_pkg.sv */
// Shared types and constants of the pan-tilt serial frame codec.
// Used by ptz_front, ptz_queue, ptz_back and the top level; depends on nothing.
`default_nettype none

package ptz_pkg;

  // Frame layout
  localparam logic [7:0] HeaderByte  = 8'hFF;
  localparam logic [7:0] CmdOneByte  = 8'h00;
  localparam logic [3:0] FrameLen    = 4'd7;
  localparam logic [3:0] SumEndPos   = 4'd6;
  localparam logic [3:0] PosFull     = 4'd8;
  localparam int         StoreBytes  = 6;
  localparam logic [2:0] LastTxPos   = 3'd6;

  // Request queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Input selector
  typedef enum logic {
    OpRecv = 1'b0,
    OpSend = 1'b1
  } op_e;

  // Result kind
  typedef enum logic {
    KindTx     = 1'b0,
    KindStatus = 1'b1
  } kind_e;

  // Receive buffer verdict
  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StEmpty    = 3'd1,
    StLength   = 3'd2,
    StAddr     = 3'd3,
    StCmd1     = 3'd4,
    StChecksum = 3'd5,
    StUnknown  = 3'd6
  } status_e;

  // Register map, word index
  typedef enum logic [1:0] {
    RegDevAddr   = 2'd0,
    RegPanCode   = 2'd1,
    RegTiltCode  = 2'd2,
    RegSpeedCode = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] dev_addr;
    logic [7:0] pan_code;
    logic [7:0] tilt_code;
    logic [7:0] speed_code;
  } cfg_t;

  // One queued request: a frame to send or a status to report
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [7:0]  data_high;
    logic [7:0]  data_low;
    logic [7:0]  sum;
    status_e     status;
    logic [15:0] pan_angle;
    logic [15:0] tilt_angle;
    logic [7:0]  pan_speed;
    logic [7:0]  tilt_speed;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/ptz_front.sv */
// Front end: takes input items, parses receive bytes and judges buffers,
// and turns each item that needs output into a queue request. Uses ptz_pkg.
`default_nettype none

module ptz_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic            op_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            buffer_end_i,
  input  wire logic [7:0]      cmd_i,
  input  wire logic [7:0]      data_high_i,
  input  wire logic [7:0]      data_low_i,
  input  wire ptz_pkg::cfg_t   cfg_i,
  output logic                 push_o,
  output ptz_pkg::entry_t      entry_o
);

  logic [3:0]  pos_q, pos_d, pos_n;
  logic [7:0]  sum_q, sum_d, sum_n;
  logic [7:0]  fb_q [ptz_pkg::StoreBytes];
  logic [7:0]  fb_e [ptz_pkg::StoreBytes];
  logic [15:0] pan_q, pan_n, tilt_q, tilt_n;
  logic [7:0]  pspd_q, pspd_n, tspd_q, tspd_n;
  logic        wr;
  logic [2:0]  idx;
  logic        rx_fire;
  ptz_pkg::status_e st;

  assign rx_fire = fire_i && (ptz_pkg::op_e'(op_i) == ptz_pkg::OpRecv);

  // Position and sum after this byte
  always_comb begin
    pos_n = pos_q;
    sum_n = sum_q;
    wr    = 1'b0;
    idx   = '0;
    if (pos_q == 4'd0) begin
      if (rx_byte_i == ptz_pkg::HeaderByte) begin
        pos_n = 4'd1;
        sum_n = '0;
      end
    end else if (pos_q < ptz_pkg::PosFull) begin
      pos_n = pos_q + 4'd1;
      if (pos_n <= ptz_pkg::FrameLen) begin
        wr  = 1'b1;
        idx = 3'(pos_q - 4'd1);
      end
      if (pos_n <= ptz_pkg::SumEndPos) begin
        sum_n = sum_q + rx_byte_i;
      end
    end
  end

  // Stored bytes as seen with this byte written
  always_comb begin
    for (int j = 0; j < ptz_pkg::StoreBytes; j++) begin
      fb_e[j] = (wr && (idx == 3'(j))) ? rx_byte_i : fb_q[j];
    end
  end

  // Buffer verdict and stored-value update
  always_comb begin
    st     = ptz_pkg::StOk;
    pan_n  = pan_q;
    tilt_n = tilt_q;
    pspd_n = pspd_q;
    tspd_n = tspd_q;
    if (pos_n == 4'd0) begin
      st = ptz_pkg::StEmpty;
    end else if (pos_n != ptz_pkg::FrameLen) begin
      st = ptz_pkg::StLength;
    end else if (fb_e[0] != cfg_i.dev_addr) begin
      st = ptz_pkg::StAddr;
    end else if (fb_e[1] != ptz_pkg::CmdOneByte) begin
      st = ptz_pkg::StCmd1;
    end else if (sum_n != fb_e[5]) begin
      st = ptz_pkg::StChecksum;
    end else if (fb_e[2] == cfg_i.pan_code) begin
      pan_n = {fb_e[3], fb_e[4]};
    end else if (fb_e[2] == cfg_i.tilt_code) begin
      tilt_n = {fb_e[3], fb_e[4]};
    end else if (fb_e[2] == cfg_i.speed_code) begin
      pspd_n = fb_e[3];
      tspd_n = fb_e[4];
    end else begin
      st = ptz_pkg::StUnknown;
    end
  end

  // Parser returns to hunting at buffer end
  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (rx_fire) begin
      pos_d = buffer_end_i ? 4'd0 : pos_n;
      sum_d = buffer_end_i ? 8'd0 : sum_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      pan_q  <= '0;
      tilt_q <= '0;
      pspd_q <= '0;
      tspd_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      if (rx_fire && buffer_end_i) begin
        pan_q  <= pan_n;
        tilt_q <= tilt_n;
        pspd_q <= pspd_n;
        tspd_q <= tspd_n;
      end
    end
  end

  // Frame byte store, no reset
  always_ff @(posedge clk_i) begin
    if (rx_fire && wr) begin
      fb_q[idx] <= rx_byte_i;
    end
  end

  // Queue request
  always_comb begin
    push_o  = fire_i && ((ptz_pkg::op_e'(op_i) == ptz_pkg::OpSend) || buffer_end_i);
    entry_o = '0;
    if (ptz_pkg::op_e'(op_i) == ptz_pkg::OpSend) begin
      entry_o.kind      = ptz_pkg::KindTx;
      entry_o.addr      = cfg_i.dev_addr;
      entry_o.cmd       = cmd_i;
      entry_o.data_high = data_high_i;
      entry_o.data_low  = data_low_i;
      entry_o.sum       = cfg_i.dev_addr + ptz_pkg::CmdOneByte + cmd_i
                          + data_high_i + data_low_i;
    end else begin
      entry_o.kind       = ptz_pkg::KindStatus;
      entry_o.status     = st;
      entry_o.pan_angle  = pan_n;
      entry_o.tilt_angle = tilt_n;
      entry_o.pan_speed  = pspd_n;
      entry_o.tilt_speed = tspd_n;
    end
  end

endmodule

`default_nettype wire

/* rtl/ptz_queue.sv */
// Short request queue between front and back, in flip-flops.
// Depth from ptz_pkg::QDepth; entries are ptz_pkg::entry_t.
`default_nettype none

module ptz_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ptz_pkg::entry_t  entry_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output ptz_pkg::entry_t       head_o
);

  ptz_pkg::entry_t           mem_q [ptz_pkg::QDepth];
  logic [ptz_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ptz_pkg::QCntW-1:0] cnt_q;

  localparam logic [ptz_pkg::QPtrW-1:0] LastPtr = ptz_pkg::QPtrW'(ptz_pkg::QDepth - 1);
  localparam logic [ptz_pkg::QCntW-1:0] FullCnt = ptz_pkg::QCntW'(ptz_pkg::QDepth);

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/ptz_back.sv */
// Back end: takes queue requests, expands send requests into seven bytes
// and drives the registered result stream. Uses ptz_pkg.
`default_nettype none

module ptz_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire ptz_pkg::entry_t  head_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [63:0]           m_axis_tdata,
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser
);

  logic [2:0]  tx_pos_q, tx_pos_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_data_q, out_data_d;
  logic        out_last_q, out_last_d;
  logic        out_kind_q, out_kind_d;
  logic        load;
  logic [7:0]  tx_byte;

  // Byte of the frame at the current position
  always_comb begin
    case (tx_pos_q)
      3'd0:    tx_byte = ptz_pkg::HeaderByte;
      3'd1:    tx_byte = head_i.addr;
      3'd2:    tx_byte = ptz_pkg::CmdOneByte;
      3'd3:    tx_byte = head_i.cmd;
      3'd4:    tx_byte = head_i.data_high;
      3'd5:    tx_byte = head_i.data_low;
      default: tx_byte = head_i.sum;
    endcase
  end

  assign load = !empty_i && (!out_valid_q || m_axis_tready);

  // Output register load and frame byte counter
  always_comb begin
    tx_pos_d    = tx_pos_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_kind_d  = out_kind_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_kind_d  = head_i.kind;
      if (head_i.kind == ptz_pkg::KindStatus) begin
        out_data_d = {5'd0, head_i.tilt_speed, head_i.pan_speed, head_i.tilt_angle,
                      head_i.pan_angle, head_i.status, 8'd0};
        out_last_d = 1'b0;
        pop_o      = 1'b1;
      end else begin
        out_data_d = {56'd0, tx_byte};
        out_last_d = (tx_pos_q == ptz_pkg::LastTxPos);
        if (tx_pos_q == ptz_pkg::LastTxPos) begin
          pop_o    = 1'b1;
          tx_pos_d = '0;
        end else begin
          tx_pos_d = tx_pos_q + 3'd1;
        end
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_pos_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tx_pos_q    <= tx_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_kind_q <= out_kind_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_kind_q;

  // Checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_pos_q <= ptz_pkg::LastTxPos)
    else $error("frame byte counter out of range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");

  a_send_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (head_i.kind == ptz_pkg::KindTx)) |=> (m_axis_tlast && tx_pos_q == 3'd0))
    else $error("send request retired before its checksum byte");

  a_status_no_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tlast)
    else $error("status result flagged as last transmit byte");

endmodule

`default_nettype wire

/* rtl/ptz_serial_frame_codec_core.sv */
// Pan-tilt serial frame codec top level: register port, front, queue, back.
// Depends on ptz_pkg, ptz_front, ptz_queue and ptz_back.
//
// Usage:
//   Input stream: tuser selects the request (0 receive one byte, 1 send one
//   frame). A receive request carries a byte in tdata[7:0] and tlast on the
//   last byte of a buffer; a send request carries command and data bytes.
//   Output stream: tuser 0 is a transmit byte (tlast on the checksum byte),
//   tuser 1 is the verdict of a receive buffer with the stored angles/speeds.
//   The first result is presented after its input accept passes the queue
//   write and then the output register load.
//   The input takes one receive byte per cycle while the queue is not full;
//   a send request occupies the output for its seven frame bytes, stepped by
//   the back end's byte counter. A two-entry request queue keeps the input
//   taking items while a frame is being sent, until the queue is full.
//   When the receiver stalls, the output register holds its result, the
//   queue fills and then the input deasserts tready.
//   Reset clears the parser, stored values, queue and output valid, and
//   loads the register defaults (address 1, reply codes 89, 91, 93).
//   The user writes registers through the APB port only while the block is idle; the block does not enforce this.
`default_nettype none

module ptz_serial_frame_codec_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] rx_byte, [15:8] cmd_code, [23:16] data_high, [31:24] data_low
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,    // buffer_end
  input  wire logic        s_axis_tuser,    // op
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] tx_byte, [10:8] status, [26:11] pan_angle, [42:27] tilt_angle,
  // [50:43] pan_speed, [58:51] tilt_speed, [63:59] zero
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tlast,    // tx_last
  output logic             m_axis_tuser,    // kind
  // Register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  ptz_pkg::cfg_t   cfg_q;
  ptz_pkg::entry_t entry, head;
  logic            push, pop, full, empty, fire, cfg_wr;

  // Register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr   <= 8'd1;
      cfg_q.pan_code   <= 8'd89;
      cfg_q.tilt_code  <= 8'd91;
      cfg_q.speed_code <= 8'd93;
    end else if (cfg_wr) begin
      unique case (ptz_pkg::reg_idx_e'(paddr[3:2]))
        ptz_pkg::RegDevAddr:   cfg_q.dev_addr   <= pwdata[7:0];
        ptz_pkg::RegPanCode:   cfg_q.pan_code   <= pwdata[7:0];
        ptz_pkg::RegTiltCode:  cfg_q.tilt_code  <= pwdata[7:0];
        ptz_pkg::RegSpeedCode: cfg_q.speed_code <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (ptz_pkg::reg_idx_e'(paddr[3:2]))
      ptz_pkg::RegDevAddr:   prdata = {24'd0, cfg_q.dev_addr};
      ptz_pkg::RegPanCode:   prdata = {24'd0, cfg_q.pan_code};
      ptz_pkg::RegTiltCode:  prdata = {24'd0, cfg_q.tilt_code};
      ptz_pkg::RegSpeedCode: prdata = {24'd0, cfg_q.speed_code};
    endcase
  end

  // Input accept
  assign s_axis_tready = !full;
  assign fire          = s_axis_tvalid && !full;

  ptz_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .op_i         (s_axis_tuser),
    .rx_byte_i    (s_axis_tdata[7:0]),
    .buffer_end_i (s_axis_tlast),
    .cmd_i        (s_axis_tdata[15:8]),
    .data_high_i  (s_axis_tdata[23:16]),
    .data_low_i   (s_axis_tdata[31:24]),
    .cfg_i        (cfg_q),
    .push_o       (push),
    .entry_o      (entry)
  );

  ptz_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  ptz_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench of the pan-tilt serial frame codec: streams send and receive
// requests with random gaps and stalls and checks every result against its own predictor.
// Depends on ptz_pkg and ptz_serial_frame_codec_core.
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit  = 800000;
  localparam int DrainCycles = 10;

  // Shapes of receive buffers the generator produces
  typedef enum int {
    BufGood,
    BufBadAddr,
    BufBadCmd1,
    BufBadSum,
    BufShort,
    BufLong,
    BufEmpty,
    BufNoise
  } buf_kind_e;

  // One result as the block should deliver it
  typedef struct {
    ptz_pkg::kind_e   kind;
    logic [7:0]       tx_byte;
    logic             tx_last;
    ptz_pkg::status_e status;
    logic [15:0]      pan_angle;
    logic [15:0]      tilt_angle;
    logic [7:0]       pan_speed;
    logic [7:0]       tilt_speed;
  } codec_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [7:0] rx_byte, [15:8] cmd_code, [23:16] data_high, [31:24] data_low
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;   // buffer_end
  logic        s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] tx_byte, [10:8] status, [26:11] pan_angle, [42:27] tilt_angle,
  // [50:43] pan_speed, [58:51] tilt_speed, [63:59] zero
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;   // tx_last
  logic        m_axis_tuser;   // kind
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the registers
  logic [7:0]  cfg_dev_addr   = 8'd1;
  logic [7:0]  cfg_pan_code   = 8'd89;
  logic [7:0]  cfg_tilt_code  = 8'd91;
  logic [7:0]  cfg_speed_code = 8'd93;

  // Predictor copy of the parser and stored reply values
  logic [3:0]  rx_pos = '0;
  logic [7:0]  rx_sum = '0;
  logic [7:0]  rx_bytes [ptz_pkg::StoreBytes];
  logic [15:0] pan_angle_q   = '0;
  logic [15:0] tilt_angle_q  = '0;
  logic [7:0]  pan_speed_q   = '0;
  logic [7:0]  tilt_speed_q  = '0;

  codec_result_t pending_results [$];
  int errors      = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  bit steady      = 1'b0;

  ptz_serial_frame_codec_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("testbench failed");
    $finish;
  end

  // Idle length: mostly none or short, now and then long; none in a steady stretch
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Alternate stretches with and without idling
  initial begin
    forever begin
      repeat ($urandom_range(150, 500)) @(negedge clk_i);
      steady = 1'b1;
      repeat ($urandom_range(40, 120)) @(negedge clk_i);
      steady = 1'b0;
    end
  end

  // Output side backpressure
  initial begin : ready_gen
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
      gap = stall_len();
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
    end
  end

  // Predict the results of one accepted request
  task automatic predict_request(input ptz_pkg::op_e op, input logic [7:0] rx,
                                 input logic last_flag, input logic [7:0] cmd,
                                 input logic [7:0] dh, input logic [7:0] dl);
    codec_result_t    r;
    logic [7:0]       frame [7];
    logic [15:0]      word;
    ptz_pkg::status_e st;
    int               i;
    if (op == ptz_pkg::OpSend) begin
      frame[0] = ptz_pkg::HeaderByte;
      frame[1] = cfg_dev_addr;
      frame[2] = ptz_pkg::CmdOneByte;
      frame[3] = cmd;
      frame[4] = dh;
      frame[5] = dl;
      frame[6] = frame[1] + frame[2] + frame[3] + frame[4] + frame[5];
      for (i = 0; i < 7; i++) begin
        r = '{ptz_pkg::KindTx, frame[i], (i == 6), ptz_pkg::StOk, 16'h0, 16'h0, 8'h0,
              8'h0};
        pending_results = {pending_results, r};
      end
    end else begin
      // Hunt for header, then count bytes, saturating past the frame length
      if (rx_pos == 4'd0) begin
        if (rx == ptz_pkg::HeaderByte) begin
          rx_pos = 4'd1;
          rx_sum = 8'h0;
        end
      end else if (rx_pos < ptz_pkg::PosFull) begin
        rx_pos = rx_pos + 4'd1;
        if (rx_pos <= ptz_pkg::FrameLen) begin
          rx_bytes[3'(rx_pos - 4'd2)] = rx;
          if (rx_pos <= ptz_pkg::SumEndPos) rx_sum = rx_sum + rx;
        end
      end
      // Judge the buffer on its last byte
      if (last_flag) begin
        if (rx_pos == 4'd0) st = ptz_pkg::StEmpty;
        else if (rx_pos != ptz_pkg::FrameLen) st = ptz_pkg::StLength;
        else if (rx_bytes[0] != cfg_dev_addr) st = ptz_pkg::StAddr;
        else if (rx_bytes[1] != ptz_pkg::CmdOneByte) st = ptz_pkg::StCmd1;
        else if (rx_sum != rx_bytes[5]) st = ptz_pkg::StChecksum;
        else begin
          word = {rx_bytes[3], rx_bytes[4]};
          st = ptz_pkg::StOk;
          if (rx_bytes[2] == cfg_pan_code) pan_angle_q = word;
          else if (rx_bytes[2] == cfg_tilt_code) tilt_angle_q = word;
          else if (rx_bytes[2] == cfg_speed_code) begin
            pan_speed_q  = rx_bytes[3];
            tilt_speed_q = rx_bytes[4];
          end else st = ptz_pkg::StUnknown;
        end
        r = '{ptz_pkg::KindStatus, 8'h0, 1'b0, st, pan_angle_q, tilt_angle_q, pan_speed_q,
              tilt_speed_q};
        pending_results = {pending_results, r};
        rx_pos = 4'd0;
        rx_sum = 8'h0;
      end
    end
  endtask

  // Input monitor feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predict_request(ptz_pkg::op_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tlast,
                      s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]);
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Output checker
  always @(posedge clk_i) begin
    codec_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        e = pending_results.pop_front();
        check_field("kind",       16'(e.kind),       16'(m_axis_tuser));
        check_field("tx_byte",    16'(e.tx_byte),    16'(m_axis_tdata[7:0]));
        check_field("tx_last",    16'(e.tx_last),    16'(m_axis_tlast));
        check_field("status",     16'(e.status),     16'(m_axis_tdata[10:8]));
        check_field("pan_angle",  e.pan_angle,       m_axis_tdata[26:11]);
        check_field("tilt_angle", e.tilt_angle,      m_axis_tdata[42:27]);
        check_field("pan_speed",  16'(e.pan_speed),  16'(m_axis_tdata[50:43]));
        check_field("tilt_speed", 16'(e.tilt_speed), 16'(m_axis_tdata[58:51]));
        check_field("pad",        16'h0,             16'(m_axis_tdata[63:59]));
      end
    end
  end

  // Present one request and hold it until accepted, then idle a while
  task automatic send_request(input ptz_pkg::op_e op, input logic [7:0] rx,
                              input logic last_flag, input logic [7:0] cmd,
                              input logic [7:0] dh, input logic [7:0] dl);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tlast  <= last_flag;
    s_axis_tdata  <= {dl, dh, cmd, rx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    gap = stall_len();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
    end
  endtask

  // Receive byte; send fields carry junk
  task automatic emit_rx(input logic [7:0] b, input logic last_flag);
    send_request(ptz_pkg::OpRecv, b, last_flag, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Send frame; receive fields carry junk
  task automatic emit_tx(input logic [7:0] cmd, input logic [7:0] dh, input logic [7:0] dl);
    send_request(ptz_pkg::OpSend, 8'($urandom), 1'($urandom_range(0, 1)), cmd, dh, dl);
  endtask

  task automatic apb_write(input ptz_pkg::reg_idx_e idx, input logic [7:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      ptz_pkg::RegDevAddr:   cfg_dev_addr   = value;
      ptz_pkg::RegPanCode:   cfg_pan_code   = value;
      ptz_pkg::RegTiltCode:  cfg_tilt_code  = value;
      ptz_pkg::RegSpeedCode: cfg_speed_code = value;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(input ptz_pkg::reg_idx_e idx, input logic [7:0] exp_v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {24'h0, exp_v}) begin
      errors++;
      $display("%0t: register %0d readback, expected %h actual %h", $time, idx,
               {24'h0, exp_v}, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop the input and let every pending result come out
  task automatic wait_for_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure(input logic [7:0] dev, input logic [7:0] pan_c,
                           input logic [7:0] tilt_c, input logic [7:0] speed_c);
    wait_for_idle();
    apb_write(ptz_pkg::RegDevAddr, dev);
    apb_write(ptz_pkg::RegPanCode, pan_c);
    apb_write(ptz_pkg::RegTiltCode, tilt_c);
    apb_write(ptz_pkg::RegSpeedCode, speed_c);
    apb_read_check(ptz_pkg::RegDevAddr, dev);
    apb_read_check(ptz_pkg::RegPanCode, pan_c);
    apb_read_check(ptz_pkg::RegTiltCode, tilt_c);
    apb_read_check(ptz_pkg::RegSpeedCode, speed_c);
  endtask

  task automatic test_register_defaults();
    apb_read_check(ptz_pkg::RegDevAddr, 8'd1);
    apb_read_check(ptz_pkg::RegPanCode, 8'd89);
    apb_read_check(ptz_pkg::RegTiltCode, 8'd91);
    apb_read_check(ptz_pkg::RegSpeedCode, 8'd93);
  endtask

  // Extremes of the send fields and the named receive corner cases, default registers
  task automatic test_directed();
    emit_tx(8'hFF, 8'hFF, 8'hFF);
    emit_tx(8'h00, 8'h00, 8'h00);
    // buffer of one non-header byte: empty
    emit_rx(8'h12, 1'b1);
    // leading junk, pan reply, a send in the middle of the buffer
    emit_rx(8'h00, 1'b0);
    emit_rx(8'hFF, 1'b0);
    emit_rx(8'h01, 1'b0);
    emit_rx(8'h00, 1'b0);
    emit_tx(8'h5A, 8'hA5, 8'h3C);
    emit_rx(8'h59, 1'b0);
    emit_rx(8'hAB, 1'b0);
    emit_rx(8'hCD, 1'b0);
    emit_rx(8'hD2, 1'b1);
    // header alone: length
    emit_rx(8'hFF, 1'b1);
    // overlong buffer, position saturates
    emit_rx(8'hFF, 1'b0);
    emit_rx(8'h01, 1'b0);
    emit_rx(8'h00, 1'b0);
    emit_rx(8'h5B, 1'b0);
    emit_rx(8'h00, 1'b0);
    emit_rx(8'h00, 1'b0);
    emit_rx(8'h5C, 1'b0);
    emit_rx(8'h77, 1'b0);
    emit_rx(8'h88, 1'b1);
  endtask

  // Build one receive buffer of the given shape and stream it
  task automatic emit_buffer(input buf_kind_e k);
    logic [7:0] bytes [$];
    logic [7:0] addr;
    logic [7:0] one;
    logic [7:0] cmd;
    logic [7:0] dh;
    logic [7:0] dl;
    logic [7:0] sum;
    int         r;
    int         i;
    int         n;
    if (k == BufNoise) begin
      n = $urandom_range(1, 10);
      repeat (n) bytes = {bytes, 8'($urandom)};
    end else begin
      n = (k == BufEmpty) ? $urandom_range(1, 3) : $urandom_range(0, 2);
      repeat (n) bytes = {bytes, 8'($urandom_range(0, 254))};
      if (k != BufEmpty) begin
        r = $urandom_range(0, 99);
        if (r < 30) cmd = cfg_pan_code;
        else if (r < 55) cmd = cfg_tilt_code;
        else if (r < 80) cmd = cfg_speed_code;
        else cmd = 8'($urandom);
        addr = cfg_dev_addr;
        one  = ptz_pkg::CmdOneByte;
        dh   = 8'($urandom);
        dl   = 8'($urandom);
        if (k == BufBadAddr) addr = cfg_dev_addr + 8'($urandom_range(1, 255));
        if (k == BufBadCmd1) one = 8'($urandom_range(1, 255));
        sum = addr + one + cmd + dh + dl;
        if (k == BufBadSum) sum = sum ^ 8'($urandom_range(1, 255));
        bytes = {bytes, ptz_pkg::HeaderByte, addr, one, cmd, dh, dl, sum};
        if (k == BufShort) begin
          n = $urandom_range(1, 6);
          repeat (n) void'(bytes.pop_back());
        end
        if (k == BufLong) begin
          n = $urandom_range(1, 3);
          repeat (n) bytes = {bytes, 8'($urandom)};
        end
      end
    end
    for (i = 0; i < bytes.size(); i++) begin
      if ($urandom_range(0, 99) < 6) emit_tx(8'($urandom), 8'($urandom), 8'($urandom));
      emit_rx(bytes[i], i == bytes.size() - 1);
    end
  endtask

  // Random traffic, well-formed replies the most common shape, ending on a buffer boundary
  task automatic test_traffic(input int count);
    int stop_at;
    int r;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 12) emit_tx(8'($urandom), 8'($urandom), 8'($urandom));
      else if (r < 50) emit_buffer(BufGood);
      else if (r < 58) emit_buffer(BufBadAddr);
      else if (r < 64) emit_buffer(BufBadCmd1);
      else if (r < 72) emit_buffer(BufBadSum);
      else if (r < 80) emit_buffer(BufShort);
      else if (r < 87) emit_buffer(BufLong);
      else if (r < 93) emit_buffer(BufEmpty);
      else emit_buffer(BufNoise);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_defaults();
    test_directed();
    test_traffic(80);
    // all reply codes equal: pan wins
    configure(8'h00, 8'h00, 8'h00, 8'h00);
    test_traffic(80);
    configure(8'hFF, 8'hFF, 8'hFF, 8'hFE);
    test_traffic(80);
    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    test_traffic(80);

    wait_for_idle();
    if (pending_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ptz_pkg.sv
rtl/ptz_front.sv
rtl/ptz_queue.sv
rtl/ptz_back.sv
rtl/ptz_serial_frame_codec_core.sv
test/testbench.sv
